### hw/rtl/xlsu_pkg.sv
// xlsu_pkg: shared types and constants for the x86 logic and shift unit
// command codes, width codes, flag and execute-result structs
// no dependencies
package xlsu_pkg;

    // operand and result width
    localparam int unsigned DATA_W = 32;

    // command codes
    typedef enum logic [3:0] {
        CMD_TEST = 4'd0,
        CMD_AND  = 4'd1,
        CMD_XOR  = 4'd2,
        CMD_OR   = 4'd3,
        CMD_SAR  = 4'd4,
        CMD_SHL  = 4'd5,
        CMD_SHLD = 4'd6,
        CMD_SHR  = 4'd7,
        CMD_SHRD = 4'd8,
        CMD_NOT  = 4'd9
    } t_cmd;

    // operand width codes; code three behaves as 32 bits
    typedef enum logic [1:0] {
        WID_8  = 2'd0,
        WID_16 = 2'd1,
        WID_32 = 2'd2,
        WID_32X = 2'd3
    } t_width;

    // stored flag state
    typedef struct packed {
        logic of;
        logic sf;
        logic zf;
        logic cf;
    } t_flags;

    // what the execute logic hands to the result register
    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic              write_back;
        t_flags            flags;
    } t_exec_out;

endpackage

### hw/rtl/xlsu_exec.sv
// xlsu_exec: combinational execute logic for one logic or shift operation
// computes result, write-back and next flags from the operands and old flags
// depends on xlsu_pkg
module xlsu_exec
    import xlsu_pkg::*;
(
    input  logic [3:0]        i_command,
    input  logic [1:0]        i_width_code,
    input  logic [DATA_W-1:0] i_dest_value,
    input  logic [DATA_W-1:0] i_src_value,
    input  logic [DATA_W-1:0] i_fill_value,
    input  t_flags            i_flags,
    output t_exec_out         o_exec
);

    logic [DATA_W-1:0]   mask;
    logic [DATA_W-1:0]   d;
    logic [DATA_W-1:0]   d_sext;
    logic [DATA_W-1:0]   sar_res;
    logic [4:0]          cnt;
    logic [2*DATA_W-1:0] pair_l;
    logic [2*DATA_W-1:0] pair_r;
    logic [2*DATA_W-1:0] shl_pair;
    logic [2*DATA_W-1:0] shr_pair;
    logic [DATA_W-1:0]   shld_res;
    logic [DATA_W-1:0]   r;
    logic                wb;
    logic                is_logic;
    logic                is_shift;
    logic                sf_bit;

    // operand masking, sign extension and the double-shift pairs per width
    always_comb begin
        case (t_width'(i_width_code))
            WID_8: begin
                mask   = 32'h0000_00FF;
                d_sext = {{24{i_dest_value[7]}}, i_dest_value[7:0]};
                pair_l = {48'b0, i_dest_value[7:0], i_fill_value[7:0]};
                pair_r = {48'b0, i_fill_value[7:0], i_dest_value[7:0]};
            end
            WID_16: begin
                mask   = 32'h0000_FFFF;
                d_sext = {{16{i_dest_value[15]}}, i_dest_value[15:0]};
                pair_l = {32'b0, i_dest_value[15:0], i_fill_value[15:0]};
                pair_r = {32'b0, i_fill_value[15:0], i_dest_value[15:0]};
            end
            default: begin
                mask   = 32'hFFFF_FFFF;
                d_sext = i_dest_value;
                pair_l = {i_dest_value, i_fill_value};
                pair_r = {i_fill_value, i_dest_value};
            end
        endcase
    end

    assign d        = i_dest_value & mask;
    assign cnt      = i_src_value[4:0];
    assign shl_pair = pair_l << cnt;
    assign shr_pair = pair_r >> cnt;

    // arithmetic shift of the sign-extended operand, kept apart from the mask
    assign sar_res  = $signed(d_sext) >>> cnt;

    // upper half of the shifted left pair
    always_comb begin
        case (t_width'(i_width_code))
            WID_8:   shld_res = {24'b0, shl_pair[15:8]};
            WID_16:  shld_res = {16'b0, shl_pair[31:16]};
            default: shld_res = shl_pair[63:32];
        endcase
    end

    // operation select
    always_comb begin
        r        = d;
        wb       = 1'b1;
        is_logic = 1'b0;
        is_shift = 1'b0;
        case (i_command)
            CMD_TEST: begin
                r        = d & i_src_value;
                wb       = 1'b0;
                is_logic = 1'b1;
            end
            CMD_AND: begin
                r        = d & i_src_value;
                is_logic = 1'b1;
            end
            CMD_XOR: begin
                r        = (d ^ i_src_value) & mask;
                is_logic = 1'b1;
            end
            CMD_OR: begin
                r        = (d | i_src_value) & mask;
                is_logic = 1'b1;
            end
            CMD_SAR: begin
                r        = sar_res & mask;
                is_shift = 1'b1;
            end
            CMD_SHL: begin
                r        = (d << cnt) & mask;
                is_shift = 1'b1;
            end
            CMD_SHR: begin
                r        = (d >> cnt) & mask;
                is_shift = 1'b1;
            end
            CMD_SHLD: begin
                r        = shld_res;
                is_shift = 1'b1;
            end
            CMD_SHRD: begin
                r        = shr_pair[DATA_W-1:0] & mask;
                is_shift = 1'b1;
            end
            CMD_NOT: begin
                r = ~d & mask;
            end
            default: begin
                r  = d;
                wb = 1'b0;
            end
        endcase
    end

    // sign bit at the operand width
    always_comb begin
        case (t_width'(i_width_code))
            WID_8:   sf_bit = r[7];
            WID_16:  sf_bit = r[15];
            default: sf_bit = r[31];
        endcase
    end

    // flag update: logic ops clear cf and of, shifts keep them
    always_comb begin
        o_exec.result     = r;
        o_exec.write_back = wb;
        o_exec.flags      = i_flags;
        if (is_logic || is_shift) begin
            o_exec.flags.zf = (r == '0);
            o_exec.flags.sf = sf_bit;
        end
        if (is_logic) begin
            o_exec.flags.cf = 1'b0;
            o_exec.flags.of = 1'b0;
        end
    end

endmodule

### hw/rtl/x86_logic_shift_unit.sv
// x86_logic_shift_unit: top level of the x86 logic and shift unit
// input register, execute logic, flag register and result register
// depends on xlsu_pkg and xlsu_exec
//
// Executes one x86 logic or shift operation (test, and, xor, or, not, shl,
// shr, sar, shld, shrd) per transfer on 8-, 16- or 32-bit operands and keeps
// CF, ZF, SF and OF between operations; all flags are zero after reset. The
// unit accepts one transfer every cycle while the master side is not stalled,
// and each transfer passes the input register and then the result register
// on its way to the master side. The flag register is updated as an
// operation moves from the input register into the result register, so flags
// always follow the order of the transfers. Shift counts use src bits [4:0];
// a double shift by zero returns dest. Command codes 10 to 15 return dest
// with write_back low and flags unchanged. A stalled master side holds both
// stages and then deasserts o_s_tready.
module x86_logic_shift_unit
    import xlsu_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    // slave side
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // [31:0] dest_value, [63:32] src_value, [95:64] fill_value
    input  logic [95:0]  i_s_tdata,
    // [3:0] command, [5:4] width_code
    input  logic [5:0]   i_s_tuser,
    // master side
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // [31:0] result, [32] zero_flag, [33] sign_flag, [34] carry_flag,
    // [35] overflow_flag, [39:36] zero
    output logic [39:0]  o_m_tdata,
    // [0] write_back
    output logic         o_m_tuser
);

    logic              r_s1_valid;
    logic [3:0]        r_s1_command;
    logic [1:0]        r_s1_width;
    logic [DATA_W-1:0] r_s1_dest;
    logic [DATA_W-1:0] r_s1_src;
    logic [DATA_W-1:0] r_s1_fill;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_result;
    logic              r_out_wb;
    t_flags            r_out_flags;
    t_flags            r_flags;
    t_exec_out         n_exec;
    logic              out_ready;
    logic              s1_move;
    logic              in_xfer;

    // handshake control
    assign out_ready  = !r_out_valid || i_m_tready;
    assign s1_move    = r_s1_valid && out_ready;
    assign o_s_tready = !r_s1_valid || out_ready;
    assign in_xfer    = i_s_tvalid && o_s_tready;

    // execute stage
    xlsu_exec u_exec (
        .i_command    (r_s1_command),
        .i_width_code (r_s1_width),
        .i_dest_value (r_s1_dest),
        .i_src_value  (r_s1_src),
        .i_fill_value (r_s1_fill),
        .i_flags      (r_flags),
        .o_exec       (n_exec)
    );

    // control registers and flag state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= '0;
        end else begin
            if (o_s_tready) begin
                r_s1_valid <= i_s_tvalid;
            end
            if (out_ready) begin
                r_out_valid <= r_s1_valid;
            end
            if (s1_move) begin
                r_flags <= n_exec.flags;
            end
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_command <= i_s_tuser[3:0];
            r_s1_width   <= i_s_tuser[5:4];
            r_s1_dest    <= i_s_tdata[31:0];
            r_s1_src     <= i_s_tdata[63:32];
            r_s1_fill    <= i_s_tdata[95:64];
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_result <= n_exec.result;
            r_out_wb     <= n_exec.write_back;
            r_out_flags  <= n_exec.flags;
        end
    end

    // master side outputs
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0, r_out_flags.of, r_out_flags.cf, r_out_flags.sf,
                         r_out_flags.zf, r_out_result};
    assign o_m_tuser  = r_out_wb;

`ifndef ASSERT_OFF
    // flags cannot move while the result register is stalled
    a_flags_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |=> $stable(r_flags))
        else $error("flag state changed while result stalled");

    // a shown result carries the current flag state
    a_out_flags_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_flags == r_flags))
        else $error("result flags differ from flag state");

    // not leaves every flag alone
    a_not_keeps_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_move && (r_s1_command == CMD_NOT)) |=> $stable(r_flags))
        else $error("not changed the flags");
`endif

endmodule
